### hw/rtl/cram4_pkg.sv
`timescale 1ns / 1ps

package cram4_pkg;

  localparam int ENTRY_BITS  = 12;
  localparam int DET_BITS    = 50;
  localparam int IDX_BITS    = 3;
  localparam int DIM         = 4;
  localparam int BANK_DEPTH  = 5;
  localparam int ADDR_BITS   = 3;
  localparam int LOAD_BITS   = 5;
  localparam int TERM_BITS_W = 5;

  localparam logic [LOAD_BITS-1:0]   LAST_LOAD = 5'd19;
  localparam logic [TERM_BITS_W-1:0] LAST_TERM = 5'd23;
  localparam logic [IDX_BITS-1:0]    DET_A     = 3'd0;
  localparam logic [IDX_BITS-1:0]    LAST_DET  = 3'd4;
  localparam logic [ADDR_BITS-1:0]   RHS_SLOT  = 3'd4;

  // One permutation term of the 4x4 determinant: column used in each row, plus parity.
  typedef struct packed {
    logic                  odd;
    logic [0:DIM-1][1:0]   col;
  } perm_t;

  // Controller to datapath: bank write and one term read per cycle.
  typedef struct packed {
    logic                              wr_en;
    logic [1:0]                        wr_row;
    logic [ADDR_BITS-1:0]              wr_addr;
    logic                              rd_en;
    logic [DIM-1:0][ADDR_BITS-1:0]     rd_addr;
    logic                              rd_odd;
    logic                              rd_first;
    logic                              rd_last;
    logic [IDX_BITS-1:0]               det_idx;
  } cmd_t;

  typedef struct packed {
    logic solve_done;
  } status_t;

  function automatic perm_t perm_entry(input logic [TERM_BITS_W-1:0] idx);
    perm_t p;
    case (idx)
      5'd0:    p = '{odd: 1'b0, col: {2'd0, 2'd1, 2'd2, 2'd3}};
      5'd1:    p = '{odd: 1'b1, col: {2'd0, 2'd1, 2'd3, 2'd2}};
      5'd2:    p = '{odd: 1'b1, col: {2'd0, 2'd2, 2'd1, 2'd3}};
      5'd3:    p = '{odd: 1'b0, col: {2'd0, 2'd2, 2'd3, 2'd1}};
      5'd4:    p = '{odd: 1'b0, col: {2'd0, 2'd3, 2'd1, 2'd2}};
      5'd5:    p = '{odd: 1'b1, col: {2'd0, 2'd3, 2'd2, 2'd1}};
      5'd6:    p = '{odd: 1'b1, col: {2'd1, 2'd0, 2'd2, 2'd3}};
      5'd7:    p = '{odd: 1'b0, col: {2'd1, 2'd0, 2'd3, 2'd2}};
      5'd8:    p = '{odd: 1'b0, col: {2'd1, 2'd2, 2'd0, 2'd3}};
      5'd9:    p = '{odd: 1'b1, col: {2'd1, 2'd2, 2'd3, 2'd0}};
      5'd10:   p = '{odd: 1'b1, col: {2'd1, 2'd3, 2'd0, 2'd2}};
      5'd11:   p = '{odd: 1'b0, col: {2'd1, 2'd3, 2'd2, 2'd0}};
      5'd12:   p = '{odd: 1'b0, col: {2'd2, 2'd0, 2'd1, 2'd3}};
      5'd13:   p = '{odd: 1'b1, col: {2'd2, 2'd0, 2'd3, 2'd1}};
      5'd14:   p = '{odd: 1'b1, col: {2'd2, 2'd1, 2'd0, 2'd3}};
      5'd15:   p = '{odd: 1'b0, col: {2'd2, 2'd1, 2'd3, 2'd0}};
      5'd16:   p = '{odd: 1'b0, col: {2'd2, 2'd3, 2'd0, 2'd1}};
      5'd17:   p = '{odd: 1'b1, col: {2'd2, 2'd3, 2'd1, 2'd0}};
      5'd18:   p = '{odd: 1'b1, col: {2'd3, 2'd0, 2'd1, 2'd2}};
      5'd19:   p = '{odd: 1'b0, col: {2'd3, 2'd0, 2'd2, 2'd1}};
      5'd20:   p = '{odd: 1'b0, col: {2'd3, 2'd1, 2'd0, 2'd2}};
      5'd21:   p = '{odd: 1'b1, col: {2'd3, 2'd1, 2'd2, 2'd0}};
      5'd22:   p = '{odd: 1'b1, col: {2'd3, 2'd2, 2'd0, 2'd1}};
      5'd23:   p = '{odd: 1'b0, col: {2'd3, 2'd2, 2'd1, 2'd0}};
      default: p = '{odd: 1'b0, col: {2'd0, 2'd1, 2'd2, 2'd3}};
    endcase
    return p;
  endfunction

endpackage

### hw/rtl/cram4_ctrl.sv
`timescale 1ns / 1ps

module cram4_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output cram4_pkg::cmd_t     cmd,
  input  cram4_pkg::status_t  status
);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                                    state, state_next;
  logic [cram4_pkg::LOAD_BITS-1:0]           load_count;
  logic [cram4_pkg::TERM_BITS_W-1:0]         term;
  logic [cram4_pkg::IDX_BITS-1:0]            det;
  cram4_pkg::perm_t                          perm;
  logic                                      load_req;
  logic [cram4_pkg::ADDR_BITS-1:0]           col_addr;

  assign busy     = (state != ST_LOAD);
  assign load_req = start && (state == ST_LOAD);
  assign perm     = cram4_pkg::perm_entry(term);

  always_comb begin
    state_next = state;
    case (state)
      ST_LOAD: begin
        if (load_req && (load_count == cram4_pkg::LAST_LOAD)) state_next = ST_RUN;
      end
      ST_RUN: begin
        if ((term == cram4_pkg::LAST_TERM) && (det == cram4_pkg::LAST_DET)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status.solve_done) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      load_count <= '0;
      term       <= '0;
      det        <= '0;
    end else begin
      state <= state_next;
      if (load_req) begin
        if (load_count == cram4_pkg::LAST_LOAD) begin
          load_count <= '0;
          term       <= '0;
          det        <= '0;
        end else begin
          load_count <= load_count + 1'b1;
        end
      end
      if (state == ST_RUN) begin
        if (term == cram4_pkg::LAST_TERM) begin
          term <= '0;
          det  <= det + 1'b1;
        end else begin
          term <= term + 1'b1;
        end
      end
    end
  end

  // Matrix entries fill rows 0..3 at slots 0..3; the right-hand side lands in slot 4.
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = load_req;
    cmd.wr_row   = load_count[4] ? load_count[1:0] : load_count[3:2];
    cmd.wr_addr  = load_count[4] ? cram4_pkg::RHS_SLOT : {1'b0, load_count[1:0]};
    cmd.rd_en    = (state == ST_RUN);
    cmd.rd_odd   = perm.odd;
    cmd.rd_first = (term == '0);
    cmd.rd_last  = (term == cram4_pkg::LAST_TERM);
    cmd.det_idx  = det;
    for (int r = 0; r < cram4_pkg::DIM; r++) begin
      col_addr = {1'b0, perm.col[r]};
      // Replace the chosen column by the right-hand side for numerators.
      if ((det != cram4_pkg::DET_A) && (col_addr == (det - 1'b1))) begin
        cmd.rd_addr[r] = cram4_pkg::RHS_SLOT;
      end else begin
        cmd.rd_addr[r] = col_addr;
      end
    end
  end

endmodule

### hw/rtl/cram4_dp.sv
`timescale 1ns / 1ps

module cram4_dp #(
  parameter int ELEMENT_BITS = 12
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [cram4_pkg::ENTRY_BITS-1:0]      entry_value,
  input  cram4_pkg::cmd_t                       cmd,
  output cram4_pkg::status_t                    status,
  output logic                                  result_valid,
  output logic [cram4_pkg::IDX_BITS-1:0]        result_index,
  output logic [cram4_pkg::DET_BITS-1:0]        det_value,
  output logic                                  singular,
  output logic                                  last
);

  localparam int PAIR_BITS = 2 * ELEMENT_BITS;
  localparam int PROD_BITS = 4 * ELEMENT_BITS;
  localparam int DIM       = cram4_pkg::DIM;
  localparam int DET_BITS  = cram4_pkg::DET_BITS;

  // One bank per row: four matrix entries and the row's right-hand side.
  logic signed [ELEMENT_BITS-1:0] bank_mem [DIM][cram4_pkg::BANK_DEPTH];
  logic signed [ELEMENT_BITS-1:0] s1_elem  [DIM];
  logic signed [PAIR_BITS-1:0]    s2_p01, s2_p23;
  logic signed [PROD_BITS-1:0]    s3_prod;
  logic signed [DET_BITS-1:0]     acc, acc_next, term_ext;
  logic                           sing_hold, acc_zero;

  typedef struct packed {
    logic                               vld;
    logic                               odd;
    logic                               first;
    logic                               lst;
    logic [cram4_pkg::IDX_BITS-1:0]     idx;
  } tag_t;

  tag_t s1_tag, s2_tag, s3_tag;

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      if (cmd.wr_en && (cmd.wr_row == r[1:0])) begin
        bank_mem[r][cmd.wr_addr] <= entry_value[ELEMENT_BITS-1:0];
      end
      s1_elem[r] <= bank_mem[r][cmd.rd_addr[r]];
    end
  end

  always_ff @(posedge clk) begin
    s2_p01  <= s1_elem[0] * s1_elem[1];
    s2_p23  <= s1_elem[2] * s1_elem[3];
    s3_prod <= s2_p01 * s2_p23;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_tag <= '0;
      s2_tag <= '0;
      s3_tag <= '0;
    end else begin
      s1_tag <= '{vld: cmd.rd_en, odd: cmd.rd_odd, first: cmd.rd_first,
                  lst: cmd.rd_last, idx: cmd.det_idx};
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
    end
  end

  assign term_ext = {{(DET_BITS-PROD_BITS){s3_prod[PROD_BITS-1]}}, s3_prod};
  assign acc_next = (s3_tag.first ? '0 : acc) + (s3_tag.odd ? -term_ext : term_ext);
  assign acc_zero = (acc_next == '0);

  always_ff @(posedge clk) begin
    if (s3_tag.vld) acc <= acc_next;
    if (s3_tag.vld && s3_tag.lst && (s3_tag.idx == cram4_pkg::DET_A)) sing_hold <= acc_zero;
    if (s3_tag.vld && s3_tag.lst) begin
      det_value    <= acc_next;
      result_index <= s3_tag.idx;
      singular     <= (s3_tag.idx == cram4_pkg::DET_A) ? acc_zero : sing_hold;
      last         <= (s3_tag.idx == cram4_pkg::LAST_DET);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s3_tag.vld && s3_tag.lst;
    end
  end

  assign status.solve_done = result_valid && last;

endmodule

### hw/rtl/cramer_4x4_integer_solver.sv
`timescale 1ns / 1ps

// Exact 4x4 determinant and Cramer numerators.
// Input: pulse start with entry_value while busy is low; each such cycle loads
// one value. Send 16 matrix entries row by row, then the 4 right-hand sides.
// Loads may arrive back to back.
// After the twentieth load busy rises. A single multiply-accumulate path walks
// the 24 permutation terms of each determinant, one term per cycle, through a
// bank read, two multiply stages and the accumulator.
// Output: five results, each shown for one cycle with result_valid high:
// det(A) first, then the numerators for x1..x4. singular is the same on all
// five; last marks the fifth. Each result appears once its determinant's last
// term has passed the accumulator; busy falls the cycle after the last result.
// The receiver cannot stall; results must be taken when shown.
// Reset returns the block to loading with the load count cleared and drops
// any solve in flight.
module cramer_4x4_integer_solver #(
  parameter int ELEMENT_BITS = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cram4_pkg::ENTRY_BITS-1:0]     entry_value,
  output logic                                 result_valid,
  output logic [cram4_pkg::IDX_BITS-1:0]       result_index,
  output logic [cram4_pkg::DET_BITS-1:0]       det_value,
  output logic                                 singular,
  output logic                                 last
);

  cram4_pkg::cmd_t    cmd;
  cram4_pkg::status_t status;

  cram4_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  cram4_dp #(
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .entry_value  (entry_value),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_index (result_index),
    .det_value    (det_value),
    .singular     (singular),
    .last         (last)
  );

endmodule

### hw/rtl/cram4_chk.sv
`timescale 1ns / 1ps

module cram4_chk (
  input logic                               clk,
  input logic                               rst,
  input logic                               busy,
  input logic                               result_valid,
  input logic [cram4_pkg::IDX_BITS-1:0]     result_index,
  input logic [cram4_pkg::DET_BITS-1:0]     det_value,
  input logic                               singular,
  input logic                               last
);

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result shown while block accepts requests");

  a_release_after_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !busy)
    else $error("busy held after final result");

  a_singular_matches_det: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result_index == cram4_pkg::DET_A)) |->
      (singular == (det_value == '0)))
    else $error("singular flag disagrees with determinant");

  a_next_result_spacing: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> ##24 (result_valid &&
      (result_index == $past(result_index, 24) + 1'b1) &&
      (singular == $past(singular, 24))))
    else $error("result order or singular flag broken within a solve");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (result_index == cram4_pkg::LAST_DET))
    else $error("last set on wrong result");

endmodule

bind cramer_4x4_integer_solver cram4_chk u_cram4_chk (.*);
